// File: hw/rtl/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg
// shared types and constants of the criterion evaluator
// ----------------------------------------------------------------------------
package tce_pkg;

  typedef enum logic [1:0] {
    VERDICT_FAIL  = 2'd0,
    VERDICT_ZERO  = 2'd1,
    VERDICT_TWICE = 2'd2
  } verdict_e;

  localparam int unsigned CoefZFirst  = 8;
  localparam int unsigned CoefZSecond = 32;
  localparam int unsigned CoefXOdd    = 2;
  localparam int unsigned CoefXEven   = 4;

endpackage : tce_pkg
`default_nettype wire

// File: hw/rtl/tce_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_value_if / tce_result_if
// valid/ready channels for input value and result transactions
// ----------------------------------------------------------------------------
interface tce_value_if #(
  parameter int unsigned VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : tce_value_if

interface tce_result_if #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            verdict;
  logic [COUNT_BITS-1:0] count_first;
  logic [COUNT_BITS-1:0] count_second;
  logic [VALUE_BITS-1:0] squarefree_core;
  modport source (output valid, output verdict, output count_first, output count_second,
                  output squarefree_core, input ready);
  modport sink   (input valid, input verdict, input count_first, input count_second,
                  input squarefree_core, output ready);
endinterface : tce_result_if
`default_nettype wire

// File: hw/rtl/tunnell_criterion_evaluator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tunnell_criterion_evaluator_unit
// squarefree core plus weighted ternary form counts and verdict
// ----------------------------------------------------------------------------
// sequence: root steps down from 2^(VALUE_BITS/2+1) to floor(sqrt(value)), then each
//   trial square is divided into value, down to the first one that divides it, followed
//   by the core division, setup, a scan over each (x,y,z) lattice point and each (x,y)
//   row (about n^1.5 points), the verdict and the output
// throughput: one transaction at a time; ready is low until the result leaves
// reset: asynchronous active low, clears the sequencer and valid flags
module tunnell_criterion_evaluator_unit
  import tce_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tce_value_if.sink    in_i,
  tce_result_if.source out_o
);
  localparam int unsigned VW = VALUE_BITS;
  // accumulation width: exact counts fit in 2*VW bits comfortably
  localparam int unsigned AW = 2 * VW + 4;
  // root index width: root <= 2^(VW/2+1)
  localparam int unsigned RW = VW / 2 + 2;
  // three bits wider for sums to catch overflow past v
  localparam int unsigned SW = VW + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_SQ, S_DIV, S_DIVW, S_CORE, S_CDIV, S_CDIVW,
    S_SETUP, S_SCAN, S_VERD, S_OUT
  } state_e;

  state_e          state_q;
  logic [VW-1:0]   val_q, v_q, core_q;
  logic [RW-1:0]   root_q;
  logic            even_q;
  logic [SW-1:0]   x_q, y_q, z_q;      // coordinates
  logic [SW-1:0]   tx_q, ty_q;         // partial sums
  logic [SW-1:0]   dxs_q;               // x increment
  logic [AW-1:0]   first_q, second_q;
  logic [1:0]      verdict_q;

  // shared divider
  logic            div_start, div_done;
  logic [VW-1:0]   div_a, div_b, div_quot, div_rem;
  logic [2*RW-1:0] sq;

  assign sq = root_q * root_q;

  tce_divider #(.W(VW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // divisor register for root squared
  logic [2*RW-1:0] sq_q;
  assign div_a     = val_q;
  assign div_b     = sq_q[VW-1:0];
  assign div_start = (state_q == S_DIV) || (state_q == S_CDIV);

  // lattice scan datapath: ta = ty + 8z^2, tb = ty + 32z^2
  logic [SW+6:0] zz8, ta, tb;
  logic [2:0]    nz;
  logic [3:0]    w;
  always_comb begin
    zz8 = (SW+7)'(z_q) * (SW+7)'(z_q) * (SW+7)'(CoefZFirst);
    ta  = (SW+7)'(ty_q) + zz8;
    tb  = (SW+7)'(ty_q) + (zz8 << 2);
    nz  = {x_q != '0, y_q != '0, z_q != '0};
    unique case (nz[0] + nz[1] + nz[2])
      2'd0:    w = 4'd1;
      2'd1:    w = 4'd2;
      2'd2:    w = 4'd4;
      default: w = 4'd8;
    endcase
  end

  logic [SW+6:0] vext;
  logic [SW+6:0] ty_next, tx_next;
  assign vext    = (SW+7)'(v_q);
  assign ty_next = (SW+7)'(tx_q) + (SW+7)'((y_q + 1'b1) * (y_q + 1'b1));
  assign tx_next = (SW+7)'(tx_q) + (SW+7)'(dxs_q);

  logic [AW-1:0] cmax;
  assign cmax = AW'({COUNT_BITS{1'b1}});

  assign in_i.ready  = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_o.valid <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_i.valid) begin
          val_q <= in_i.value;
          // start root at 2^(VW/2+1), above the sqrt of any value
          root_q <= RW'(1) << (VW/2 + 1);
          state_q <= (in_i.value == '0) ? S_CORE : S_ROOT;
        end
        // step root down until root^2 <= value
        S_ROOT: begin
          if (sq <= (2*RW)'(val_q)) begin
            sq_q    <= sq;
            state_q <= S_DIV;
          end else begin
            root_q <= root_q - 1'b1;
          end
        end
        S_DIV:  state_q <= S_DIVW;
        S_DIVW: if (div_done) begin
          if (div_rem == '0) begin
            state_q <= S_CDIV;
          end else begin
            root_q  <= root_q - 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sq_q    <= sq;
          state_q <= S_DIV;
        end
        S_CDIV: state_q <= S_CDIVW;
        S_CDIVW: if (div_done) begin
          core_q  <= div_quot;
          even_q  <= ~div_quot[0];
          v_q     <= div_quot[0] ? div_quot : (div_quot >> 1);
          state_q <= S_SETUP;
        end
        // zero value: core is zero
        S_CORE: begin
          core_q  <= '0;
          even_q  <= 1'b1;
          v_q     <= '0;
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          x_q <= '0; y_q <= '0; z_q <= '0;
          tx_q <= '0; ty_q <= '0;
          // (x+1)^2 - x^2 scaled: c*(2x+1), start at x=0
          dxs_q <= even_q ? SW'(CoefXEven) : SW'(CoefXOdd);
          first_q <= '0; second_q <= '0;
          state_q <= S_SCAN;
        end
        // one lattice point per cycle, apart from cycles that advance y or x
        S_SCAN: begin
          if (ta <= vext) begin
            if (ta == vext) first_q  <= first_q + AW'(w);
            if (tb == vext) second_q <= second_q + AW'(w);
            z_q <= z_q + 1'b1;
          end else if (z_q != '0 && ty_next <= vext) begin
            y_q  <= y_q + 1'b1;
            ty_q <= ty_next[SW-1:0];
            z_q  <= '0;
          end else if (tx_next <= vext && (z_q != '0 || y_q != '0 || x_q == '0)) begin
            x_q   <= x_q + 1'b1;
            tx_q  <= tx_next[SW-1:0];
            ty_q  <= tx_next[SW-1:0];
            dxs_q <= dxs_q + (even_q ? SW'(2*CoefXEven) : SW'(2*CoefXOdd));
            y_q   <= '0;
            z_q   <= '0;
          end else begin
            state_q <= S_VERD;
          end
        end
        S_VERD: begin
          if (first_q == '0 && second_q == '0) verdict_q <= VERDICT_ZERO;
          else if (second_q != '0 && first_q == (second_q << 1)) verdict_q <= VERDICT_TWICE;
          else verdict_q <= VERDICT_FAIL;
          out_o.valid <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: if (out_o.ready) begin
          out_o.valid <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.verdict         = verdict_q;
  assign out_o.count_first     = (first_q > cmax) ? {COUNT_BITS{1'b1}} : first_q[COUNT_BITS-1:0];
  assign out_o.count_second    = (second_q > cmax) ? {COUNT_BITS{1'b1}} : second_q[COUNT_BITS-1:0];
  assign out_o.squarefree_core = core_q;
endmodule : tunnell_criterion_evaluator_unit
`default_nettype wire

// File: hw/rtl/tce_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tce_divider #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quot_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [W:0]      trial;

  assign trial = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q  <= trial[W-1:0];
        quot_q <= {quot_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[W-2:0], quot_q[W-1]};
        quot_q <= {quot_q[W-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule : tce_divider
`default_nettype wire

// File: hw/rtl/tce_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_checker
// port-level checks of the criterion evaluator
// ----------------------------------------------------------------------------
module tce_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] verdict_i
);
  // never ready for a new transaction while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("ready while result pending");
  // accepting an input drops ready next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  // verdict code in range
  a_verd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> verdict_i != 2'd3) else $error("bad verdict");
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(verdict_i))
    else $error("result dropped");
endmodule : tce_checker

bind tunnell_criterion_evaluator_unit tce_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .verdict_i  (out_o.verdict)
);
`default_nettype wire
